@@ hw/rtl/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 digest package
// Shared types, constants and round functions for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef logic [31:0] word_t;

    // Five 32-bit words; index 0 is H0 (or working variable a).
    typedef logic [4:0][31:0] hash_t;

    localparam hash_t HASH_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                   32'hefcdab89, 32'h67452301};

    localparam int          ROUND_CNT_W = 7;
    localparam logic [6:0]  LAST_ROUND  = 7'd79;
    localparam logic [6:0]  SCHED_DEPTH = 7'd16;

    localparam logic [7:0]  PAD_MARKER      = 8'h80;
    localparam logic [5:0]  LEN_FIELD_START = 6'd56;
    localparam logic [5:0]  BLOCK_LAST      = 6'd63;
    localparam logic [1:0]  WORD_LAST_BYTE  = 2'd3;
    localparam logic [2:0]  DIGEST_LAST     = 3'd4;
    localparam logic [63:0] BITS_PER_BYTE   = 64'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [1:0] {
        CP_IDLE,
        CP_ROUND,
        CP_ADD
    } core_phase_t;

    typedef struct packed {
        logic word_load;
        logic start;
        logic chain_reset;
    } core_ctrl_t;

    function automatic word_t round_k(logic [6:0] t);
        word_t k;
        priority if (t < 7'd20) k = 32'h5a827999;
        else if (t < 7'd40)     k = 32'h6ed9eba1;
        else if (t < 7'd60)     k = 32'h8f1bbcdc;
        else                    k = 32'hca62c1d6;
        return k;
    endfunction

    function automatic word_t round_f(logic [6:0] t, word_t b, word_t c, word_t d);
        word_t f;
        priority if (t < 7'd20) f = (b & c) | (~b & d);
        else if (t < 7'd40)     f = b ^ c ^ d;
        else if (t < 7'd60)     f = (b & c) | (b & d) | (c & d);
        else                    f = b ^ c ^ d;
        return f;
    endfunction

endpackage

@@ hw/rtl/sha1_in_if.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message byte channel
// Valid/ready channel carrying one message byte and the end marker.
// ----------------------------------------------------------------------------
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic       byte_present;
    logic [7:0] msg_byte;
    logic       end_of_message;

    modport source (output valid, byte_present, msg_byte, end_of_message,
                    input ready);
    modport sink   (input valid, byte_present, msg_byte, end_of_message,
                    output ready);
endinterface

@@ hw/rtl/sha1_out_if.sv @@
// ----------------------------------------------------------------------------
// SHA-1 digest word channel
// Valid/ready channel carrying one 32-bit digest word with its position.
// ----------------------------------------------------------------------------
interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    modport source (output valid, digest_word, word_index, final_word,
                    input ready);
    modport sink   (input valid, digest_word, word_index, final_word,
                    output ready);
endinterface

@@ hw/rtl/sha1_message_digest_top.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Streams message bytes into 512-bit blocks, pads at end of message and
// returns the five digest words.
// ----------------------------------------------------------------------------
//  channel     dir  payload                                   request means
//  msg_in      in   byte_present, msg_byte, end_of_message    one byte and/or end
//  digest_out  out  digest_word, word_index, final_word       one digest word
//
//  A request is taken when msg_in is ready; the 64th byte of a block starts
//  the round unit, which holds msg_in not ready for 80 rounds and a hash add.
//  End of message: pad bytes go in one per cycle (9 to 72), with a compression
//  per filled block, then five digest words, each held until taken.
//  Reset loads the initial hash; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha1_message_digest_top (
    input  logic            clk,
    input  logic            rst_n,
    sha1_in_if.sink         msg_in,
    sha1_out_if.source      digest_out
);

    sha1_pkg::ctl_state_t state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [23:0] acc_reg, acc_next;
    logic        end_reg, end_next;
    logic        marker_reg, marker_next;
    logic        len_phase_reg, len_phase_next;
    logic [2:0]  idx_reg, idx_next;

    logic        in_take;
    logic        out_take;
    logic        put_en;
    logic [7:0]  put_byte;
    logic [7:0]  pad_byte;
    logic [63:0] len_shifted;

    sha1_pkg::core_ctrl_t ctrl;
    sha1_pkg::word_t      load_word;
    logic                 core_done;
    sha1_pkg::hash_t      hash;

    sha1_round_unit u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .load_word (load_word),
        .done      (core_done),
        .hash      (hash)
    );

    assign in_take  = msg_in.valid && msg_in.ready;
    assign out_take = digest_out.valid && digest_out.ready;

    // length bytes go out MSB first at fill 56..63
    assign len_shifted = bits_reg >> {~fill_reg[2:0], 3'b000};

    always_comb
    begin
        priority if (!marker_reg)
            pad_byte = sha1_pkg::PAD_MARKER;
        else if (len_phase_reg || fill_reg == sha1_pkg::LEN_FIELD_START)
            pad_byte = len_shifted[7:0];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        state_next       = state_reg;
        bits_next        = bits_reg;
        end_next         = end_reg;
        marker_next      = marker_reg;
        len_phase_next   = len_phase_reg;
        idx_next         = idx_reg;
        put_en           = 1'b0;
        put_byte         = pad_byte;
        ctrl             = '0;
        msg_in.ready     = 1'b0;
        digest_out.valid = 1'b0;

        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                msg_in.ready = 1'b1;
                if (in_take)
                begin
                    end_next = msg_in.end_of_message;
                    if (msg_in.byte_present)
                    begin
                        put_en    = 1'b1;
                        put_byte  = msg_in.msg_byte;
                        bits_next = bits_reg + sha1_pkg::BITS_PER_BYTE;
                    end
                    priority if (msg_in.byte_present && fill_reg == sha1_pkg::BLOCK_LAST)
                    begin
                        ctrl.start = 1'b1;
                        state_next = sha1_pkg::ST_ROUND;
                    end
                    else if (msg_in.end_of_message)
                    begin
                        state_next = sha1_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = sha1_pkg::ST_IDLE;
                    end
                end
            end
            sha1_pkg::ST_PAD:
            begin
                put_en = 1'b1;
                priority if (!marker_reg)
                    marker_next = 1'b1;
                else if (fill_reg == sha1_pkg::LEN_FIELD_START)
                    len_phase_next = 1'b1;
                else
                    len_phase_next = len_phase_reg;
                if (fill_reg == sha1_pkg::BLOCK_LAST)
                begin
                    ctrl.start = 1'b1;
                    state_next = sha1_pkg::ST_ROUND;
                end
            end
            sha1_pkg::ST_ROUND:
            begin
                if (core_done)
                begin
                    priority if (!end_reg)
                        state_next = sha1_pkg::ST_IDLE;
                    else if (len_phase_reg)
                        state_next = sha1_pkg::ST_OUT;
                    else
                        state_next = sha1_pkg::ST_PAD;
                end
            end
            sha1_pkg::ST_OUT:
            begin
                digest_out.valid = 1'b1;
                if (out_take)
                begin
                    if (idx_reg == sha1_pkg::DIGEST_LAST)
                    begin
                        ctrl.chain_reset = 1'b1;
                        bits_next        = '0;
                        end_next         = 1'b0;
                        marker_next      = 1'b0;
                        len_phase_next   = 1'b0;
                        idx_next         = '0;
                        state_next       = sha1_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase

        // big-endian byte packing into schedule words
        fill_next = fill_reg;
        acc_next  = acc_reg;
        load_word = {acc_reg, put_byte};
        if (put_en)
        begin
            fill_next = fill_reg + 1'b1;
            acc_next  = {acc_reg[15:0], put_byte};
            if (fill_reg[1:0] == sha1_pkg::WORD_LAST_BYTE)
            begin
                ctrl.word_load = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1_pkg::ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            end_reg       <= 1'b0;
            marker_reg    <= 1'b0;
            len_phase_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            end_reg       <= end_next;
            marker_reg    <= marker_next;
            len_phase_reg <= len_phase_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign digest_out.digest_word = hash[idx_reg];
    assign digest_out.word_index  = idx_reg;
    assign digest_out.final_word  = (idx_reg == sha1_pkg::DIGEST_LAST);

endmodule

@@ hw/rtl/sha1_round_unit.sv @@
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Message schedule shift line, working variables and chaining hash; runs one
// compression round per cycle, then adds the result into the chaining hash.
// ----------------------------------------------------------------------------
module sha1_round_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::core_ctrl_t ctrl,
    input  sha1_pkg::word_t     load_word,
    output logic                done,
    output sha1_pkg::hash_t     hash
);

    // sched_reg[0] is the oldest word of the 16-word window
    sha1_pkg::word_t     sched_reg [16];
    sha1_pkg::hash_t     vars_reg;
    sha1_pkg::hash_t     chain_reg;
    logic [sha1_pkg::ROUND_CNT_W-1:0] cnt_reg, cnt_next;
    sha1_pkg::core_phase_t phase_reg, phase_next;

    sha1_pkg::word_t w_mix;
    sha1_pkg::word_t w_cur;
    sha1_pkg::word_t a_rot;
    sha1_pkg::word_t b_rot;
    sha1_pkg::word_t tmp;

    always_comb
    begin
        w_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        w_cur = (cnt_reg < sha1_pkg::SCHED_DEPTH) ? sched_reg[0]
                                                  : {w_mix[30:0], w_mix[31]};
        a_rot = {vars_reg[0][26:0], vars_reg[0][31:27]};
        b_rot = {vars_reg[1][1:0], vars_reg[1][31:2]};
        tmp   = a_rot
              + sha1_pkg::round_f(cnt_reg, vars_reg[1], vars_reg[2], vars_reg[3])
              + vars_reg[4] + w_cur + sha1_pkg::round_k(cnt_reg);
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        unique case (phase_reg)
            sha1_pkg::CP_IDLE:
            begin
                cnt_next = '0;
                if (ctrl.start)
                begin
                    phase_next = sha1_pkg::CP_ROUND;
                end
            end
            sha1_pkg::CP_ROUND:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == sha1_pkg::LAST_ROUND)
                begin
                    phase_next = sha1_pkg::CP_ADD;
                end
            end
            sha1_pkg::CP_ADD:
            begin
                cnt_next   = '0;
                phase_next = sha1_pkg::CP_IDLE;
            end
            default:
            begin
                cnt_next   = '0;
                phase_next = sha1_pkg::CP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sha1_pkg::CP_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    // first 16 rounds rotate the window so it returns to W0..W15
    always_ff @(posedge clk)
    begin
        if (phase_reg == sha1_pkg::CP_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[15] <= w_cur;
        end
        else if (ctrl.word_load)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[15] <= load_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            vars_reg <= chain_reg;
        end
        else if (phase_reg == sha1_pkg::CP_ROUND)
        begin
            vars_reg[4] <= vars_reg[3];
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= b_rot;
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= tmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= sha1_pkg::HASH_INIT;
        end
        else if (ctrl.chain_reset)
        begin
            chain_reg <= sha1_pkg::HASH_INIT;
        end
        else if (phase_reg == sha1_pkg::CP_ADD)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= chain_reg[i] + vars_reg[i];
            end
        end
    end

    assign done = (phase_reg == sha1_pkg::CP_ADD);
    assign hash = chain_reg;

endmodule

@@ tb/sha1_message_digest_top_tb.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams messages into the hasher over the valid/ready byte channel and checks
// every digest word against a behavioral SHA-1 model kept in step with the
// accepted requests, or a directed row's known digest. A directed table (empty
// message, "abc", single bytes, idle requests) comes first, then randomly sized
// messages of random bytes under changing idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module sha1_message_digest_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_AFTER     = 140;
    localparam int HOLD_CYCLES    = 500;
    localparam int PHASE_END [3]  = '{60, 120, 180};
    localparam int DIRECTED_ROWS  = 16;

    localparam sha1_pkg::hash_t EMPTY_DIGEST = {32'hafd80709, 32'h95601890,
                                                32'h3255bfef, 32'h5e6b4b0d,
                                                32'hda39a3ee};
    localparam sha1_pkg::hash_t ABC_DIGEST   = {32'h9cd0d89d, 32'h7850c26c,
                                                32'hba3e2571, 32'h4706816a,
                                                32'ha9993e36};

    typedef struct {
        logic            present;
        logic [7:0]      data;
        logic            eom;
        bit              has_digest;
        sha1_pkg::hash_t digest;
    } stim_row_t;

    typedef struct {
        sha1_pkg::word_t word;
        logic [2:0]      index;
        logic            last;
    } digest_word_t;

    logic clk;
    logic rst_n;

    sha1_in_if  msg_in ();
    sha1_out_if digest_out ();

    sha1_message_digest_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_in     (msg_in),
        .digest_out (digest_out)
    );

    // model state
    sha1_pkg::hash_t chain_h;
    sha1_pkg::word_t sched [16];
    logic [5:0]      fill;
    logic [63:0]     msg_bits;

    digest_word_t pending_digest [$];
    int           mismatch_count = 0;
    int           random_items = 0;
    int           tx_idle_pct = 11;
    int           rx_idle_pct = 55;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, 8'h00, 1'b1, 1'b1, EMPTY_DIGEST},   // empty message right after reset
        '{1'b1, 8'h61, 1'b0, 1'b0, '0},
        '{1'b1, 8'h62, 1'b0, 1'b0, '0},
        '{1'b1, 8'h63, 1'b1, 1'b1, ABC_DIGEST},     // last byte carries the end
        '{1'b0, 8'hff, 1'b0, 1'b0, '0},             // idle request, ignored
        '{1'b1, 8'hff, 1'b0, 1'b0, '0},
        '{1'b0, 8'h5a, 1'b0, 1'b0, '0},
        '{1'b1, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, 8'hff, 1'b1, 1'b0, '0},             // end only, byte field ignored
        '{1'b1, 8'h00, 1'b1, 1'b0, '0},
        '{1'b1, 8'hff, 1'b1, 1'b0, '0},
        '{1'b0, 8'h00, 1'b1, 1'b1, EMPTY_DIGEST},   // state back to initial after digest
        '{1'b1, 8'h61, 1'b0, 1'b0, '0},
        '{1'b1, 8'h62, 1'b0, 1'b0, '0},
        '{1'b1, 8'h63, 1'b0, 1'b0, '0},
        '{1'b0, 8'h00, 1'b1, 1'b1, ABC_DIGEST}
    };

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic sha1_pkg::word_t rotl(sha1_pkg::word_t x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void compress_block();
        sha1_pkg::word_t a, b, c, d, e, w, f, k, sum;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t < 16)
                w = sched[t];
            else
            begin
                w = rotl(sched[(t - 3) & 15] ^ sched[(t - 8) & 15] ^
                         sched[(t - 14) & 15] ^ sched[t & 15], 1);
                sched[t & 15] = w;
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5a827999;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ed9eba1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8f1bbcdc;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hca62c1d6;
            end
            sum = rotl(a, 5) + f + e + w + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = sum;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // big-endian packing; the 64th byte triggers a compression
    function automatic void place_byte(logic [7:0] data);
        logic [3:0] widx;
        int         sh;
        widx = fill[5:2];
        sh   = (3 - fill[1:0]) * 8;
        if (fill[1:0] == 2'd0)
            sched[widx] = sha1_pkg::word_t'(data) << sh;
        else
            sched[widx] |= sha1_pkg::word_t'(data) << sh;
        if (fill == sha1_pkg::BLOCK_LAST)
            compress_block();
        fill = fill + 6'd1;
    endfunction

    function automatic void restart_message();
        chain_h  = sha1_pkg::HASH_INIT;
        fill     = '0;
        msg_bits = '0;
    endfunction

    // advances the model by one request; returns 1 with the digest on end of message
    function automatic bit sha1_absorb(input logic present, input logic [7:0] data,
                                       input logic eom, output sha1_pkg::hash_t digest);
        logic [63:0] len;
        digest = '0;
        if (present)
        begin
            place_byte(data);
            msg_bits += sha1_pkg::BITS_PER_BYTE;
        end
        if (!eom)
            return 1'b0;
        len = msg_bits;
        place_byte(sha1_pkg::PAD_MARKER);
        while (fill != sha1_pkg::LEN_FIELD_START)
            place_byte(8'h00);
        for (int s = 56; s >= 0; s -= 8)
            place_byte(len[s +: 8]);
        digest = chain_h;
        restart_message();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @ %0t ns: %s", $realtime, what);
        mismatch_count++;
    endtask

    // starts and ends at a falling edge; valid stays up for a following request
    task automatic send_request(input logic present, input logic [7:0] data,
                                input logic eom, input bit has_digest,
                                input sha1_pkg::hash_t known);
        sha1_pkg::hash_t digest;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            msg_in.valid <= 1'b0;
            @(negedge clk);
        end
        msg_in.valid          <= 1'b1;
        msg_in.byte_present   <= present;
        msg_in.msg_byte       <= data;
        msg_in.end_of_message <= eom;
        @(posedge clk);
        while (!msg_in.ready)
            @(posedge clk);
        if (sha1_absorb(present, data, eom, digest))
        begin
            if (has_digest)
                digest = known;
            for (int k = 0; k < 5; k++)
                pending_digest.push_back('{digest[k], 3'(k),
                                           3'(k) == sha1_pkg::DIGEST_LAST});
        end
        @(negedge clk);
    endtask

    // one message of random bytes, with some idle requests mixed in
    task automatic send_message(input int len);
        bit end_with_byte;
        end_with_byte = (len > 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(11) == 0)
                send_request(1'b0, 8'($urandom), 1'b0, 1'b0, '0);
            send_request(1'b1, 8'($urandom), end_with_byte && (i == len - 1), 1'b0, '0);
            random_items++;
        end
        if (!end_with_byte)
        begin
            send_request(1'b0, 8'($urandom), 1'b1, 1'b0, '0);
            random_items++;
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(12);
        if (r < 90)
            return $urandom_range(63, 13);
        // lengths where the padding spills into an extra block or fills one exactly
        unique case ($urandom_range(5))
            0: return 55;
            1: return 56;
            2: return 63;
            3: return 64;
            4: return 119;
            default: return 120;
        endcase
    endfunction

    // ends at a rising edge with nothing outstanding
    task automatic drain_digests();
        msg_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_digest.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls plus one long hold-off so the hasher backs up
    always @(negedge clk)
    begin
        static int hold_left = 0;
        static bit hold_done = 1'b0;
        if (!rst_n)
            digest_out.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            digest_out.ready <= 1'b0;
        end
        else if (!hold_done && random_items >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            digest_out.ready <= 1'b0;
        end
        else
            digest_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        digest_word_t exp;
        if (rst_n && digest_out.valid && digest_out.ready)
        begin
            if (pending_digest.size() == 0)
                report_mismatch($sformatf("unexpected digest word %h index %0d",
                                          digest_out.digest_word, digest_out.word_index));
            else
            begin
                exp = pending_digest.pop_front();
                if (digest_out.digest_word !== exp.word)
                    report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                              digest_out.digest_word, exp.word, exp.index));
                if (digest_out.word_index !== exp.index)
                    report_mismatch($sformatf("word_index %0d, expected %0d",
                                              digest_out.word_index, exp.index));
                if (digest_out.final_word !== exp.last)
                    report_mismatch($sformatf("final_word %b, expected %b (index %0d)",
                                              digest_out.final_word, exp.last, exp.index));
            end
        end
    end

    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n                 = 1'b0;
        msg_in.valid          = 1'b0;
        msg_in.byte_present   = 1'b0;
        msg_in.msg_byte       = 8'h00;
        msg_in.end_of_message = 1'b0;
        restart_message();
        for (int i = 0; i < 16; i++)
            sched[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].present, directed_rows[i].data,
                         directed_rows[i].eom, directed_rows[i].has_digest,
                         directed_rows[i].digest);

        for (int phase = 0; phase < 3; phase++)
        begin
            while (random_items < PHASE_END[phase])
                send_message(pick_length());
            // sender goes quiet until the hasher has delivered everything
            drain_digests();
            if (phase == 0)
            begin
                tx_idle_pct = 55;
                rx_idle_pct = 11;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_in_if.sv
hw/rtl/sha1_out_if.sv
hw/rtl/sha1_round_unit.sv
hw/rtl/sha1_message_digest_top.sv
tb/sha1_message_digest_top_tb.sv
